// ===== hw/rtl/wzh_pkg.sv =====
// ----------------------------------------------------------------------------
// wzh_pkg: shared types and constants of the weighted z histogram peak finder
// Holds the request and result payload types, controller command and status
// structs, size constants and the bin count clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package wzh_pkg;

  localparam int MAX_BINS    = 4096;
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int CNT_W       = BIN_W + 1;
  localparam int LG_HI       = $clog2(MAX_BINS + 1) - 1;
  localparam int LG_W        = 4;
  localparam int Z_SPAN_LOG2 = 16;
  localparam int SUM_W       = 32;

  localparam logic [LG_W-1:0] LOG2_MIN   = 4'd7;
  localparam logic [LG_W-1:0] LOG2_MAX   = 4'd12;
  localparam logic [LG_W-1:0] LOG2_RESET = 4'd12;

  typedef struct packed {
    logic signed [17:0] track_z;
    logic [15:0]        track_pt;
    logic               last_track;
  } in_req_t;

  typedef struct packed {
    logic [11:0]        peak_bin;
    logic signed [15:0] peak_low_edge;
    logic signed [16:0] peak_high_edge;
    logic [31:0]        peak_weight;
    logic               event_empty;
  } out_res_t;

  typedef struct packed {
    logic accept;
    logic acc;
    logic scan_init;
    logic sweep;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic sweep_done;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [LG_W-1:0] eff_lg(input logic [LG_W-1:0] cfg);
    logic [LG_W-1:0] lg;
    lg = cfg;
    if (lg < LOG2_MIN) begin
      lg = LOG2_MIN;
    end
    if (lg > LOG2_MAX) begin
      lg = LOG2_MAX;
    end
    if (lg > LG_W'(LG_HI)) begin
      lg = LG_W'(LG_HI);
    end
    return lg;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wzh_ram.sv =====
// ----------------------------------------------------------------------------
// wzh_ram: generic simple dual port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wzh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wzh_ctrl.sv =====
// ----------------------------------------------------------------------------
// wzh_ctrl: sequencer of the histogram peak finder
// Steps through clear, request accept, accumulate, scan and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module wzh_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire wzh_pkg::ctrl_sts_t sts,
  output wzh_pkg::ctrl_cmd_t      cmd
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_CLR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.last) begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wzh_dp.sv =====
// ----------------------------------------------------------------------------
// wzh_dp: datapath of the histogram peak finder
// Bin index, saturating accumulate, bin sweep with max search and clear,
// edge computation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wzh_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [wzh_pkg::LG_W-1:0]    cfg_wdata,
  input  wire wzh_pkg::in_req_t            in_data,
  input  wire wzh_pkg::ctrl_cmd_t          cmd,
  output wzh_pkg::ctrl_sts_t               sts,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output wzh_pkg::out_res_t                out_data
);

  logic [wzh_pkg::LG_W-1:0]  cfg_r;
  logic [wzh_pkg::LG_W-1:0]  used_lg_r;
  logic [wzh_pkg::LG_W-1:0]  scan_lg_r;
  logic [wzh_pkg::BIN_W-1:0] idx_r;
  logic [15:0]               pt_r;
  logic                      inrange_r;
  logic                      last_r;
  logic [wzh_pkg::CNT_W-1:0] rd_cnt_r;
  logic [wzh_pkg::CNT_W-1:0] sweep_n_r;
  logic [wzh_pkg::CNT_W-1:0] scan_n_r;
  logic                      v_r;
  logic [wzh_pkg::BIN_W-1:0] a_r;
  logic [wzh_pkg::BIN_W-1:0] best_r;
  logic [wzh_pkg::SUM_W-1:0] best_w_r;
  logic                      out_valid_r;
  wzh_pkg::out_res_t         out_r;

  logic [wzh_pkg::LG_W-1:0]  lg;
  logic [wzh_pkg::LG_W-1:0]  sweep_lg;
  logic [4:0]                shift_in;
  logic [4:0]                shift_scan;
  logic                      in_range;
  logic [15:0]               pos;
  logic [wzh_pkg::BIN_W-1:0] idx_in;
  logic                      rd_more;
  logic                      ram_rd_en;
  logic [wzh_pkg::BIN_W-1:0] ram_rd_addr;
  logic [wzh_pkg::SUM_W-1:0] ram_rd_data;
  logic                      ram_wr_en;
  logic [wzh_pkg::BIN_W-1:0] ram_wr_addr;
  logic [wzh_pkg::SUM_W-1:0] ram_wr_data;
  logic [wzh_pkg::SUM_W:0]   sum_ext;
  logic [wzh_pkg::SUM_W-1:0] sum_sat;
  logic                      better;
  logic [15:0]               lo_off;
  logic signed [15:0]        lo_edge;
  logic [16:0]               bin_span;
  logic signed [16:0]        hi_edge;
  wzh_pkg::out_res_t         res;

  assign lg         = wzh_pkg::eff_lg(cfg_r);
  assign sweep_lg   = (lg > used_lg_r) ? lg : used_lg_r;
  assign shift_in   = 5'(wzh_pkg::Z_SPAN_LOG2) - {1'b0, lg};
  assign shift_scan = 5'(wzh_pkg::Z_SPAN_LOG2) - {1'b0, scan_lg_r};
  assign in_range   = (in_data.track_z[17:15] == 3'b000) ||
                      (in_data.track_z[17:15] == 3'b111);
  assign pos        = {~in_data.track_z[15], in_data.track_z[14:0]};
  assign idx_in     = wzh_pkg::BIN_W'(pos >> shift_in);
  assign rd_more    = (rd_cnt_r != sweep_n_r);

  assign ram_rd_en   = cmd.accept || (cmd.sweep && rd_more);
  assign ram_rd_addr = cmd.accept ? idx_in : rd_cnt_r[wzh_pkg::BIN_W-1:0];

  assign sum_ext     = {1'b0, ram_rd_data} + (wzh_pkg::SUM_W + 1)'(pt_r);
  assign sum_sat     = sum_ext[wzh_pkg::SUM_W] ? '1 : sum_ext[wzh_pkg::SUM_W-1:0];
  assign ram_wr_en   = (cmd.acc && inrange_r) || (cmd.sweep && v_r);
  assign ram_wr_addr = cmd.acc ? idx_r : a_r;
  assign ram_wr_data = cmd.acc ? sum_sat : '0;

  assign better = v_r && ({1'b0, a_r} < scan_n_r) && (ram_rd_data > best_w_r);

  assign lo_off   = 16'(32'(best_r) << shift_scan);
  assign lo_edge  = signed'(lo_off ^ 16'h8000);
  assign bin_span = 17'(1) << shift_scan;
  assign hi_edge  = signed'({lo_edge[15], lo_edge} + bin_span);

  always_comb begin
    res.peak_bin       = 12'(best_r);
    res.peak_low_edge  = lo_edge;
    res.peak_high_edge = hi_edge;
    res.peak_weight    = best_w_r;
    res.event_empty    = (best_w_r == '0);
  end

  assign sts.last       = last_r;
  assign sts.sweep_done = !rd_more && !v_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  wzh_ram #(
    .WIDTH(wzh_pkg::SUM_W),
    .DEPTH(wzh_pkg::MAX_BINS)
  ) u_bins (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= wzh_pkg::LOG2_RESET;
      used_lg_r   <= wzh_pkg::LOG2_MIN;
      rd_cnt_r    <= '0;
      sweep_n_r   <= wzh_pkg::CNT_W'(wzh_pkg::MAX_BINS);
      v_r         <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (cmd.accept && in_range && (lg > used_lg_r)) begin
        used_lg_r <= lg;
      end
      if (cmd.scan_init) begin
        used_lg_r <= wzh_pkg::LOG2_MIN;
        rd_cnt_r  <= '0;
        sweep_n_r <= wzh_pkg::CNT_W'(1) << sweep_lg;
        v_r       <= 1'b0;
      end else if (cmd.sweep) begin
        v_r <= rd_more;
        if (rd_more) begin
          rd_cnt_r <= rd_cnt_r + 1'b1;
        end
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r     <= idx_in;
      pt_r      <= in_data.track_pt;
      inrange_r <= in_range;
      last_r    <= in_data.last_track;
    end
    if (cmd.sweep) begin
      a_r <= rd_cnt_r[wzh_pkg::BIN_W-1:0];
    end
    if (cmd.scan_init) begin
      scan_n_r  <= wzh_pkg::CNT_W'(1) << lg;
      scan_lg_r <= lg;
      best_r    <= '0;
      best_w_r  <= '0;
    end else if (cmd.sweep && better) begin
      best_r   <= a_r;
      best_w_r <= ram_rd_data;
    end
    if (cmd.load) begin
      out_r <= res;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a result still waiting");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("result register not valid after load");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_cnt_r <= sweep_n_r)
    else $error("sweep counter ran past sweep length");

  a_pipe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> ({1'b0, a_r} < sweep_n_r))
    else $error("sweep data address out of range");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.event_empty == (out_r.peak_weight == '0)))
    else $error("empty flag disagrees with peak weight");

endmodule

`default_nettype wire

// ===== hw/rtl/weighted_z_histogram_peak_finder.sv =====
// ----------------------------------------------------------------------------
// weighted_z_histogram_peak_finder: z0 histogram primary vertex peak finder
// Accumulates track pt into z0 bins and reports the heaviest bin per event.
// ----------------------------------------------------------------------------
// Tracks arrive on the in_ channel (valid/stall), one request per track with
// track_z, track_pt and last_track. For each track the bin is read from the
// histogram memory at accept and the saturated sum is written back in the
// next cycle; in_stall stays high during the write-back.
// After the track marked last the block sweeps the bins through the memory's
// single read port, one bin per cycle, searching for the first maximum and
// zeroing each bin behind the read. The sweep covers the bins in use, or more
// when a larger bin count was in force earlier in the event; then the result
// is loaded into the out_ register.
// The result waits in that register while out_stall is high; the block then
// holds in_stall high until the result can be loaded, and accepts tracks of
// the next event as soon as it is loaded.
// bin_count_log2 is written through cfg_we/cfg_wdata and is clamped to 7..12.
// After reset the block runs a clearing pass over all 4096 bins with in_stall
// high; configuration writes are taken during it.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_z_histogram_peak_finder (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [wzh_pkg::LG_W-1:0] cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire wzh_pkg::in_req_t         in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output wzh_pkg::out_res_t             out_data
);

  wzh_pkg::ctrl_cmd_t cmd;
  wzh_pkg::ctrl_sts_t sts;

  wzh_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  wzh_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
